/* sv/assert_macros.svh */
// Assertion macros shared by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define LPR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define LPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/lpr_pkg.sv */
// Package for the LRU page replacement block: sizes, codes, item types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpr_pkg;

  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 16;

  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int PAGE_W = 16;
  localparam int FIDX_W = 4;
  localparam int CNT_W  = 32;
  localparam int CFG_W  = 5;
  localparam int CMP_W  = ((IDX_W > CFG_W) ? IDX_W : CFG_W) + 1;

  localparam logic [PAGE_W-1:0] PAGE_MASK =
    (PAGE_BITS >= PAGE_W) ? {PAGE_W{1'b1}} : PAGE_W'((64'd1 << PAGE_BITS) - 64'd1);

  localparam logic [CFG_W-1:0] FIU_RESET = 5'd16;
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  // APB data and address
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  // Input kind codes
  localparam logic KIND_REF     = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic {
    CMD_REF,
    CMD_RESTART
  } cmd_op_e;

  typedef enum logic {
    ST_LOOK,
    ST_COMMIT
  } back_state_e;

  typedef struct packed {
    logic              kind;
    logic [PAGE_W-1:0] page;
  } lpr_in_t;

  typedef struct packed {
    logic              hit;
    logic [FIDX_W-1:0] frame_index;
    logic              evicted_valid;
    logic [PAGE_W-1:0] evicted_page;
    logic [CNT_W-1:0]  fault_count;
  } lpr_out_t;

  typedef struct packed {
    cmd_op_e           op;
    logic [PAGE_W-1:0] page;
  } lpr_cmd_t;

endpackage

`default_nettype wire

/* sv/lpr_front.sv */
// Front end: accepts items, decodes them into commands, holds a short queue.
// Depends on lpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpr_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire lpr_pkg::lpr_in_t  item_i,
  output logic                   full_o,
  output logic                   cmd_valid_o,
  output lpr_pkg::lpr_cmd_t      cmd_o,
  input  wire logic              cmd_pop_i
);
  import lpr_pkg::*;

  lpr_cmd_t          slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  lpr_cmd_t          cmd_new;
  logic              do_push, do_pop;

  always_comb begin
    cmd_new.op   = (item_i.kind == KIND_RESTART) ? CMD_RESTART : CMD_REF;
    cmd_new.page = item_i.page & PAGE_MASK;
  end

  assign full_o      = (cnt_q == QCNT_W'(QDEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = slot_q[rd_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

/* sv/lpr_back.sv */
// Back end: frame table, recency ranks, fault counter and result register.
// Depends on lpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpr_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cmd_valid_i,
  input  wire lpr_pkg::lpr_cmd_t         cmd_i,
  output logic                           cmd_pop_o,
  input  wire logic [lpr_pkg::CFG_W-1:0] frames_in_use_i,
  output logic                           empty_o,
  input  wire logic                      pop_i,
  output lpr_pkg::lpr_out_t              item_o
);
  import lpr_pkg::*;

  back_state_e       state_q, state_d;

  logic [PAGE_W-1:0] page_q [FRAMES];
  logic [RANK_W-1:0] rank_q [FRAMES];
  logic [RANK_W-1:0] rank_upd [FRAMES];
  logic [FRAMES-1:0] valid_q;
  logic [CNT_W-1:0]  fault_q, fault_inc;

  logic [FRAMES-1:0] active, match, free, victim;
  logic [FRAMES-1:0] hit_oh_q, free_oh_q, vic_oh_q;
  logic              any_hit_q, any_free_q;

  logic [FRAMES-1:0] sel;
  logic [IDX_W-1:0]  idx;
  logic [RANK_W-1:0] old_rank;
  logic [PAGE_W-1:0] sel_page;
  logic              fill;

  lpr_out_t          out_q;
  logic              out_valid_q;
  logic              do_look, do_commit;

  // Lookup: per-frame compares, reduced to one-hot picks
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      active[i] = (i == 0) || (CMP_W'(i) < CMP_W'(frames_in_use_i));
      match[i]  = active[i] && valid_q[i] && (page_q[i] == cmd_i.page);
      free[i]   = active[i] && !valid_q[i];
    end
    for (int i = 0; i < FRAMES; i++) begin
      victim[i] = active[i];
      for (int j = 0; j < FRAMES; j++) begin
        if (j < i && active[j] && !(rank_q[i] > rank_q[j])) begin
          victim[i] = 1'b0;
        end
        if (j > i && active[j] && !(rank_q[i] >= rank_q[j])) begin
          victim[i] = 1'b0;
        end
      end
    end
  end

  // Commit: chosen frame and the new recency order
  always_comb begin
    sel      = any_hit_q ? hit_oh_q : (any_free_q ? free_oh_q : vic_oh_q);
    fill     = !any_hit_q && any_free_q;
    idx      = '0;
    old_rank = '0;
    sel_page = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (sel[i]) begin
        idx      = idx | IDX_W'(i);
        old_rank = old_rank | rank_q[i];
        sel_page = sel_page | page_q[i];
      end
    end
    for (int i = 0; i < FRAMES; i++) begin
      rank_upd[i] = rank_q[i];
      if (sel[i]) begin
        rank_upd[i] = '0;
      end else if (valid_q[i] && (fill || rank_q[i] < old_rank)) begin
        rank_upd[i] = rank_q[i] + 1'b1;
      end
    end
    fault_inc = (fault_q == CNT_MAX) ? fault_q : fault_q + 1'b1;
  end

  always_comb begin
    state_d   = state_q;
    do_look   = 1'b0;
    do_commit = 1'b0;
    unique case (state_q)
      ST_LOOK: begin
        if (cmd_valid_i) begin
          do_look = 1'b1;
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!out_valid_q || pop_i) begin
          do_commit = 1'b1;
          state_d   = ST_LOOK;
        end
      end
      default: state_d = ST_LOOK;
    endcase
  end

  assign cmd_pop_o = do_commit;
  assign empty_o   = !out_valid_q;
  assign item_o    = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOOK;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      fault_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (do_commit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      if (do_commit) begin
        if (cmd_i.op == CMD_RESTART) begin
          valid_q <= '0;
          fault_q <= '0;
          for (int i = 0; i < FRAMES; i++) begin
            rank_q[i] <= '0;
          end
        end else begin
          valid_q <= valid_q | sel;
          for (int i = 0; i < FRAMES; i++) begin
            rank_q[i] <= rank_upd[i];
          end
          if (!any_hit_q) begin
            fault_q <= fault_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_look) begin
      hit_oh_q   <= match & (~match + FRAMES'(1));
      free_oh_q  <= free & (~free + FRAMES'(1));
      vic_oh_q   <= victim;
      any_hit_q  <= |match;
      any_free_q <= |free;
    end
    if (do_commit) begin
      if (cmd_i.op == CMD_RESTART) begin
        out_q <= '0;
      end else begin
        for (int i = 0; i < FRAMES; i++) begin
          if (sel[i] && !any_hit_q) begin
            page_q[i] <= cmd_i.page;
          end
        end
        out_q.hit           <= any_hit_q;
        out_q.frame_index   <= FIDX_W'(idx);
        out_q.evicted_valid <= !any_hit_q && !any_free_q;
        out_q.evicted_page  <= (!any_hit_q && !any_free_q) ? sel_page : '0;
        out_q.fault_count   <= any_hit_q ? fault_q : fault_inc;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/lru_page_replacement.sv */
// LRU page replacement, top level: configuration register and the two ends.
// Results are registered after the lookup and commit steps over the frame table;
// the next item is looked up once the last is committed; a held result stalls commit.
// Reset empties all frames, clears the fault count and sets frames_in_use to 16;
// there is no clearing pass, items are taken from the first cycle after reset.
// Depends on lpr_pkg, lpr_front and lpr_back.
`timescale 1ns / 1ps
`default_nettype none

module lru_page_replacement (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push,
  output logic                            full,
  input  wire lpr_pkg::lpr_in_t           in_item_i,
  output logic                            empty,
  input  wire logic                       pop,
  output lpr_pkg::lpr_out_t               out_item_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lpr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lpr_pkg::DATA_W-1:0] pwdata,
  output logic [lpr_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);
  import lpr_pkg::*;

  logic [CFG_W-1:0] fiu_q;
  logic             cmd_valid, cmd_pop;
  lpr_cmd_t         cmd;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1] == REG_FRAMES_IN_USE);
  assign prdata  = reg_sel ? DATA_W'(fiu_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q <= FIU_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      fiu_q <= pwdata[CFG_W-1:0];
    end
  end

  lpr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (in_item_i),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  lpr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .frames_in_use_i (fiu_q),
    .empty_o         (empty),
    .pop_i           (pop),
    .item_o          (out_item_o)
  );

endmodule

`default_nettype wire

/* sv/lpr_checker.sv */
// Port-level checks on result items of the LRU page replacement block.
// Depends on lpr_pkg and assert_macros.svh; bound to lru_page_replacement.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lpr_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              empty,
  input wire logic              pop,
  input wire lpr_pkg::lpr_out_t out_item_o
);
  import lpr_pkg::*;

  `LPR_ASSERT_ALWAYS(a_empty_in_reset, clk_i, !rst_ni |-> empty, "result shown during reset")

  `LPR_ASSERT(a_hit_no_evict, clk_i, rst_ni, (!empty && out_item_o.hit) |-> (!out_item_o.evicted_valid && out_item_o.evicted_page == '0), "hit item reports an eviction")

  `LPR_ASSERT(a_evict_is_fault, clk_i, rst_ni, (!empty && out_item_o.evicted_valid) |-> (out_item_o.fault_count != '0), "eviction without a counted fault")

  `LPR_ASSERT(a_result_held, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(out_item_o)), "waiting result changed or dropped")

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (.*);

`default_nettype wire

/* tb/tb_lru_page_replacement.sv */
`timescale 1ns / 1ps
// Self-checking testbench for lru_page_replacement: directed and random page references,
// restarts and frame-count settings, each result checked against an LRU frame table model.
// Depends on lpr_pkg and the lru_page_replacement RTL.

module tb_lru_page_replacement;
  import lpr_pkg::*;

  localparam logic [ADDR_W-1:0] FIU_ADDR = ADDR_W'(4 * REG_FRAMES_IN_USE);

  logic              clk_i     = 1'b0;
  logic              rst_ni;
  logic              push      = 1'b0;
  logic              full;
  lpr_in_t           in_item_i = '0;
  logic              empty;
  logic              pop       = 1'b0;
  lpr_out_t          out_item_o;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // frame table model
  logic [PAGE_W-1:0] tbl_page  [FRAMES];
  bit                tbl_valid [FRAMES];
  logic [RANK_W-1:0] tbl_rank  [FRAMES];
  logic [CNT_W-1:0]  tbl_faults = '0;
  logic [CFG_W-1:0]  tbl_frames = FIU_RESET;

  lpr_out_t expected_lookups[$];
  int       fail_count    = 0;
  int       send_idle_pct = 0;
  int       pop_stall_pct = 0;
  int       pop_hold      = 0;

  lru_page_replacement i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  initial begin
    for (int i = 0; i < FRAMES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_rank[i]  = '0;
    end
  end

  function automatic lpr_out_t lru_lookup(input lpr_in_t it);
    lpr_out_t          res;
    logic [PAGE_W-1:0] pg;
    logic [RANK_W-1:0] old_rank;
    int                active;
    int                idx;
    bit                found;
    bit                was_valid;
    res       = '0;
    pg        = it.page & PAGE_MASK;
    active    = int'(tbl_frames);
    idx       = 0;
    found     = 1'b0;
    was_valid = 1'b1;
    if (active < 1) active = 1;
    if (active > FRAMES) active = FRAMES;
    if (it.kind == KIND_RESTART) begin
      for (int i = 0; i < FRAMES; i++) begin
        tbl_valid[i] = 1'b0;
        tbl_rank[i]  = '0;
      end
      tbl_faults = '0;
    end else begin
      for (int i = 0; i < active; i++) begin
        if (!found && tbl_valid[i] && tbl_page[i] == pg) begin
          found = 1'b1;
          idx   = i;
        end
      end
      if (found) begin
        res.hit = 1'b1;
      end else begin
        for (int i = 0; i < active; i++) begin
          if (!found && !tbl_valid[i]) begin
            found = 1'b1;
            idx   = i;
          end
        end
        if (found) begin
          was_valid      = 1'b0;
          tbl_valid[idx] = 1'b1;
        end else begin
          // lowest index wins among equal ranks
          for (int i = 1; i < active; i++) begin
            if (tbl_rank[i] > tbl_rank[idx]) idx = i;
          end
          res.evicted_valid = 1'b1;
          res.evicted_page  = tbl_page[idx];
        end
        tbl_page[idx] = pg;
        if (tbl_faults != CNT_MAX) tbl_faults++;
      end
      old_rank = tbl_rank[idx];
      for (int i = 0; i < FRAMES; i++) begin
        if (i != idx && tbl_valid[i] && (!was_valid || tbl_rank[i] < old_rank)) begin
          tbl_rank[i]++;
        end
      end
      tbl_rank[idx] = '0;
    end
    res.frame_index = FIDX_W'(idx);
    res.fault_count = tbl_faults;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // result side: stalls, long hold-off, checks
  always @(negedge clk_i) begin
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    lpr_out_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_lookups.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_item_o);
      end else begin
        want = expected_lookups.pop_front();
        check_field("hit", 32'(want.hit), 32'(out_item_o.hit));
        check_field("frame_index", 32'(want.frame_index), 32'(out_item_o.frame_index));
        check_field("evicted_valid", 32'(want.evicted_valid), 32'(out_item_o.evicted_valid));
        check_field("evicted_page", 32'(want.evicted_page), 32'(out_item_o.evicted_page));
        check_field("fault_count", want.fault_count, out_item_o.fault_count);
      end
    end
  end

  task automatic send_item(input lpr_in_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full);
    expected_lookups.push_back(lru_lookup(it));
  endtask

  task automatic send_page(input logic [PAGE_W-1:0] pg);
    send_item(lpr_in_t'{kind: KIND_REF, page: pg});
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    push <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk_i);
  endtask

  // write then read back frames_in_use, only with the table idle
  task automatic set_frames(input logic [CFG_W-1:0] val);
    drain_results();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FIU_ADDR;
    pwdata  <= DATA_W'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tbl_frames = val;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("frames_in_use", DATA_W'(val), prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_fill_and_evict();
    set_frames(5'd4);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h1234);
    send_page(16'hABCD);
    send_page(16'hFFFF);
    send_page(16'h5555);
    send_page(16'h0000);
  endtask

  task automatic test_restart();
    send_item(lpr_in_t'{kind: KIND_RESTART, page: 16'hFFFF});
    send_page(16'hFFFF);
  endtask

  // same page held twice after the frame count shrinks, upper frames keep their pages
  task automatic test_shared_page();
    set_frames(5'd16);
    send_item(lpr_in_t'{kind: KIND_RESTART, page: 16'h0000});
    for (int i = 0; i < 6; i++) send_page(16'h0100 + PAGE_W'(i));
    set_frames(5'd2);
    send_page(16'h0105);
    set_frames(5'd16);
    send_page(16'h0105);
    send_page(16'h0104);
  endtask

  task automatic test_frame_limits();
    set_frames(5'd0);
    send_page(16'h00AA);
    send_page(16'h0055);
    set_frames(5'd31);
    send_page(16'h00AA);
  endtask

  task automatic test_backpressure();
    logic [PAGE_W-1:0] pg;
    set_frames(5'd5);
    send_idle_pct = 0;
    pop_stall_pct = 0;
    pop_hold      = 80;
    repeat (30) begin
      pg = PAGE_W'($urandom_range(7));
      send_page(pg);
    end
    drain_results();
    repeat (10) begin
      pg = PAGE_W'($urandom_range(7));
      send_page(pg);
    end
  endtask

  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct, input logic [CFG_W-1:0] frames,
                                     input int ws);
    logic [PAGE_W-1:0] pool [24];
    lpr_in_t           it;
    int                sel;
    set_frames(frames);
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    foreach (pool[i]) pool[i] = PAGE_W'($urandom);
    repeat (n_items) begin
      sel     = $urandom_range(99);
      it.kind = (sel < 3) ? KIND_RESTART : KIND_REF;
      it.page = (sel < 78) ? pool[$urandom_range(ws - 1)] : PAGE_W'($urandom);
      send_item(it);
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_fill_and_evict();
    test_restart();
    test_shared_page();
    test_frame_limits();
    test_backpressure();
    test_random_traffic(180, 0, 0, 5'd16, 22);
    test_random_traffic(180, 69, 0, 5'd1, 3);
    test_random_traffic(180, 0, 69, 5'd7, 10);
    test_random_traffic(180, 7, 7, CFG_W'($urandom_range(16, 1)), 20);
    pop_stall_pct = 0;
    send_idle_pct = 0;
    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
